@@ sv/sapg_pkg.sv @@
// Shared types, constants and register codes of the servo angle PWM generator.
package sapg_pkg;

	localparam int DEF_DUTY_BITS  = 14;
	localparam int DEF_COUNT_BITS = 16;

	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int MUL_W    = 20;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int NUM_W    = 36;
	localparam int DEN_W    = 20;
	localparam int PERIOD_W = 16;

	localparam logic [2:0] REG_ANGLE_LOW  = 3'd0;
	localparam logic [2:0] REG_ANGLE_HIGH = 3'd1;
	localparam logic [2:0] REG_PULSE_LOW  = 3'd2;
	localparam logic [2:0] REG_PULSE_HIGH = 3'd3;
	localparam logic [2:0] REG_PERIOD     = 3'd4;

	localparam logic [2:0] OP_ANGLE  = 3'd0;
	localparam logic [2:0] OP_DUTY   = 3'd1;
	localparam logic [2:0] OP_PAUSE  = 3'd2;
	localparam logic [2:0] OP_RESUME = 3'd3;
	localparam logic [2:0] OP_TICK   = 3'd4;

	localparam logic signed [9:0] RST_ANGLE_LOW  = 10'sd0;
	localparam logic signed [9:0] RST_ANGLE_HIGH = 10'sd180;
	localparam logic [13:0]       RST_PULSE_LOW  = 14'd400;
	localparam logic [13:0]       RST_PULSE_HIGH = 14'd2090;
	localparam logic [15:0]       RST_PERIOD     = 16'd20000;

	typedef struct packed {
		logic signed [9:0]     angle_low;
		logic signed [9:0]     angle_high;
		logic [13:0]           pulse_low;
		logic [13:0]           pulse_high;
		logic [PERIOD_W-1:0]   period_len;
	} cfg_t;

endpackage

@@ sv/sapg_cfg.sv @@
// APB-style register file holding the angle, pulse and period settings.
module sapg_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sapg_pkg::ADDR_W-1:0] paddr,
	input  logic [sapg_pkg::DATA_W-1:0] pwdata,
	output logic [sapg_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output sapg_pkg::cfg_t              cfg
);
	import sapg_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_low    <= RST_ANGLE_LOW;
			cfg_q.angle_high   <= RST_ANGLE_HIGH;
			cfg_q.pulse_low    <= RST_PULSE_LOW;
			cfg_q.pulse_high   <= RST_PULSE_HIGH;
			cfg_q.period_len   <= RST_PERIOD;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ANGLE_LOW:  cfg_q.angle_low    <= pwdata[9:0];
				REG_ANGLE_HIGH: cfg_q.angle_high   <= pwdata[9:0];
				REG_PULSE_LOW:  cfg_q.pulse_low    <= pwdata[13:0];
				REG_PULSE_HIGH: cfg_q.pulse_high   <= pwdata[13:0];
				REG_PERIOD:     cfg_q.period_len   <= pwdata[PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_ANGLE_LOW:  prdata = DATA_W'(cfg_q.angle_low);
			REG_ANGLE_HIGH: prdata = DATA_W'(cfg_q.angle_high);
			REG_PULSE_LOW:  prdata = DATA_W'(cfg_q.pulse_low);
			REG_PULSE_HIGH: prdata = DATA_W'(cfg_q.pulse_high);
			REG_PERIOD:     prdata = DATA_W'(cfg_q.period_len);
			default:        prdata = '0;
		endcase
	end

endmodule

@@ sv/sapg_mul.sv @@
// Shared signed multiplier with a registered product.
module sapg_mul (
	input  logic                               clk,
	input  logic signed [sapg_pkg::MUL_W-1:0]  a,
	input  logic signed [sapg_pkg::MUL_W-1:0]  b,
	output logic signed [sapg_pkg::PROD_W-1:0] prod_q
);
	import sapg_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

@@ sv/sapg_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module sapg_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [sapg_pkg::NUM_W-1:0] num,
	input  logic signed [sapg_pkg::DEN_W-1:0] den,
	output logic                              done_q,
	output logic signed [sapg_pkg::NUM_W-1:0] quot
);
	import sapg_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] a_q;
	logic [DEN_W-1:0] b_q;
	logic [DEN_W-1:0] rem_q;
	logic             neg_q;
	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q, a_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, b_q};
	assign diff  = trial - {1'b0, b_q};
	assign quot  = neg_q ? -$signed(a_q) : $signed(a_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand magnitudes are loaded on start; the quotient builds in the numerator register.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			b_q   <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
			rem_q <= '0;
			neg_q <= num[NUM_W-1] ^ den[DEN_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			a_q   <= {a_q[NUM_W-2:0], ge};
		end
	end

endmodule

@@ sv/servo_angle_pwm_generator.sv @@
// Top level of the servo angle PWM generator: sequencer, PWM state and output register.
// Each transaction takes one opcode and returns one result; in_stall stays high until the
// result has been loaded into the output register. Pause, timer tick, unknown opcodes and
// resume while running go from decode straight to the result; set duty, resume while paused
// and set angle over an equal angle range pass the clamps and, while running, the compare
// product. Set angle is dominated by the 36-bit signed divider that retires one quotient bit
// per cycle, after two products on the shared multiplier and before the clamps and, while
// running, the compare product. The next transaction can be accepted at the edge after
// out_valid rises; a result that must wait for a stalled output register adds those
// cycles. A new compare value takes effect when the period counter wraps to zero.
module servo_angle_pwm_generator #(
	parameter int DUTY_BITS  = sapg_pkg::DEF_DUTY_BITS,
	parameter int COUNT_BITS = sapg_pkg::DEF_COUNT_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sapg_pkg::ADDR_W-1:0] paddr,
	input  logic [sapg_pkg::DATA_W-1:0] pwdata,
	output logic [sapg_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [2:0]                  opcode,
	input  logic signed [17:0]          value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        pwm_level,
	output logic [15:0]                 compare_ticks,
	output logic [DUTY_BITS-1:0]        stored_duty,
	output logic                        is_paused
);
	import sapg_pkg::*;

	localparam int XW = (COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W;
	localparam logic signed [NUM_W-1:0] DUTY_MAX_N = NUM_W'((1 << DUTY_BITS) - 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_MA    = 4'd2;
	localparam logic [3:0] S_MB    = 4'd3;
	localparam logic [3:0] S_SUM   = 4'd4;
	localparam logic [3:0] S_DIV   = 4'd5;
	localparam logic [3:0] S_CLAMP = 4'd6;
	localparam logic [3:0] S_MC    = 4'd7;
	localparam logic [3:0] S_PC    = 4'd8;
	localparam logic [3:0] S_RES   = 4'd9;

	cfg_t cfg;

	logic [3:0]              state_q;
	logic [2:0]              op_q;
	logic signed [17:0]      value_q;
	logic                    map_q;
	logic signed [NUM_W-1:0] dval_q;
	logic signed [PROD_W-1:0] acc_q;

	logic [DUTY_BITS-1:0]    last_duty_q;
	logic                    paused_q;
	logic [15:0]             pending_q;
	logic [15:0]             active_q;
	logic [COUNT_BITS-1:0]   cnt_q;

	logic                    out_valid_q;
	logic                    pwm_level_q;
	logic [15:0]             compare_q;
	logic [DUTY_BITS-1:0]    duty_out_q;
	logic                    paused_out_q;

	logic                    in_accept;
	logic                    out_free;

	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod;

	logic signed [17:0]      al256;
	logic signed [18:0]      dx;
	logic signed [14:0]      dp;
	logic signed [14:0]      pl_s;
	logic signed [10:0]      da;
	logic signed [18:0]      den;
	logic [PERIOD_W-1:0]     eff_period;

	logic signed [NUM_W-1:0] num;
	logic                    div_start;
	logic                    div_done;
	logic signed [NUM_W-1:0] quot;

	logic signed [NUM_W-1:0] pl_n;
	logic signed [NUM_W-1:0] ph_n;
	logic signed [NUM_W-1:0] lo_cl;
	logic signed [NUM_W-1:0] hi_cl;
	logic signed [NUM_W-1:0] pre_duty;
	logic signed [NUM_W-1:0] duty_n;

	logic                    wrap;
	logic                    cnt_lt;

	sapg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sapg_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	sapg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (DEN_W'(den)),
		.done_q (div_done),
		.quot   (quot)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid & ~in_stall;
	assign out_free  = ~out_valid_q | ~out_stall;

	// Operands of the linear angle map.
	assign al256      = {cfg.angle_low, 8'b0};
	assign dx         = 19'(value_q) - 19'(al256);
	assign dp         = $signed({1'b0, cfg.pulse_high}) - $signed({1'b0, cfg.pulse_low});
	assign pl_s       = $signed({1'b0, cfg.pulse_low});
	assign da         = 11'(cfg.angle_high) - 11'(cfg.angle_low);
	assign den        = {da, 8'b0};
	assign eff_period = (cfg.period_len == '0) ? PERIOD_W'(1) : cfg.period_len;

	assign num       = NUM_W'(acc_q + prod);
	assign div_start = (state_q == S_SUM);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MA: begin
				mul_a = MUL_W'(dx);
				mul_b = MUL_W'(dp);
			end
			S_MB: begin
				mul_a = MUL_W'(pl_s);
				mul_b = MUL_W'(den);
			end
			S_MC: begin
				mul_a = $signed(MUL_W'({1'b0, last_duty_q}));
				mul_b = $signed(MUL_W'({1'b0, eff_period}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// An angle result is first held to the pulse range, lower bound first, and every duty
	// is then held to the duty range.
	assign pl_n     = $signed(NUM_W'({1'b0, cfg.pulse_low}));
	assign ph_n     = $signed(NUM_W'({1'b0, cfg.pulse_high}));
	assign lo_cl    = (dval_q < pl_n) ? pl_n : dval_q;
	assign hi_cl    = (lo_cl > ph_n) ? ph_n : lo_cl;
	assign pre_duty = map_q ? hi_cl : dval_q;
	assign duty_n   = (pre_duty < 0) ? '0 : ((pre_duty > DUTY_MAX_N) ? DUTY_MAX_N : pre_duty);

	// The counter wraps at the end of the period or when it would overflow.
	assign wrap   = (XW'(cnt_q) >= XW'(eff_period - 1'b1)) || (cnt_q == '1);
	assign cnt_lt = XW'(cnt_q) < XW'(active_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_duty_q <= '0;
			paused_q    <= 1'b0;
			pending_q   <= '0;
			active_q    <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					state_q <= S_RES;
					case (op_q)
						OP_ANGLE: begin
							state_q <= (da == '0) ? S_CLAMP : S_MA;
						end
						OP_DUTY: begin
							state_q <= S_CLAMP;
						end
						OP_PAUSE: begin
							if (!paused_q) begin
								pending_q <= '0;
								paused_q  <= 1'b1;
							end
						end
						OP_RESUME: begin
							if (paused_q) begin
								paused_q <= 1'b0;
								state_q  <= S_CLAMP;
							end
						end
						OP_TICK: begin
							if (wrap) begin
								cnt_q    <= '0;
								active_q <= pending_q;
							end else begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				S_MA:  state_q <= S_MB;
				S_MB:  state_q <= S_SUM;
				S_SUM: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					last_duty_q <= duty_n[DUTY_BITS-1:0];
					state_q     <= paused_q ? S_RES : S_MC;
				end
				S_MC: state_q <= S_PC;
				S_PC: begin
					// The duty is below 2^DUTY_BITS, so the scaled value stays below the period.
					pending_q <= prod[DUTY_BITS +: 16];
					state_q   <= S_RES;
				end
				S_RES: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q    <= opcode;
			value_q <= value;
		end
		case (state_q)
			S_DEC: begin
				case (op_q)
					OP_ANGLE: begin
						map_q  <= 1'b1;
						dval_q <= pl_n;
					end
					OP_DUTY: begin
						map_q  <= 1'b0;
						dval_q <= NUM_W'(value_q);
					end
					OP_RESUME: begin
						map_q  <= 1'b0;
						dval_q <= $signed(NUM_W'({1'b0, last_duty_q}));
					end
					default: begin
					end
				endcase
			end
			S_MB: acc_q <= prod;
			S_DIV: begin
				if (div_done) begin
					dval_q <= quot;
				end
			end
			S_RES: begin
				if (out_free) begin
					pwm_level_q  <= cnt_lt;
					compare_q    <= active_q;
					duty_out_q   <= last_duty_q;
					paused_out_q <= paused_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign pwm_level     = pwm_level_q;
	assign compare_ticks = compare_q;
	assign stored_duty   = duty_out_q;
	assign is_paused     = paused_out_q;

	// While paused, the compare value waiting for the next wrap must be zero.
	a_paused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		paused_q |-> (pending_q == '0))
		else $error("pending compare is nonzero while paused");

	// Only one transaction is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> in_stall)
		else $error("input taken while a transaction is in work");

	// A result is presented only when the sequencer finishes a transaction.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_RES))
		else $error("result presented outside the result step");

endmodule

@@ dv/tb_servo_angle_pwm_generator.sv @@
// Self-checking testbench for the servo angle PWM generator: directed and random stimulus.
`timescale 1ns / 1ps

module tb_servo_angle_pwm_generator;
	import sapg_pkg::*;

	localparam longint DUTY_TOP = (longint'(1) << DEF_DUTY_BITS) - 1;

	typedef struct {
		logic [2:0]         op;
		logic signed [17:0] val;
	} servo_cmd_t;

	typedef struct {
		logic        level;
		logic [15:0] cmp;
		logic [13:0] duty;
		logic        paused;
	} pwm_result_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [2:0]          opcode = OP_TICK;
	logic signed [17:0]  value = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                pwm_level;
	logic [15:0]         compare_ticks;
	logic [13:0]         stored_duty;
	logic                is_paused;

	// Configuration and PWM state as the block should hold them.
	cfg_t        cfg;
	logic [13:0] m_duty;
	logic        m_paused;
	logic [15:0] m_pend;
	logic [15:0] m_active;
	logic [15:0] m_count;

	servo_cmd_t  cmd_q[$];
	pwm_result_t pwm_result_q[$];

	int n_errors = 0;
	int n_taken = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_at = 0;
	logic long_hold = 1'b0;
	int stall_mode = 0;
	int mode_left = 0;
	int stall_phase = 0;
	logic stall_next;
	servo_cmd_t next_cmd;
	pwm_result_t want;

	servo_angle_pwm_generator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pwm_level     (pwm_level),
		.compare_ticks (compare_ticks),
		.stored_duty   (stored_duty),
		.is_paused     (is_paused)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic flag_error(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		n_errors++;
	endtask

	task automatic compare_field(input string name, input longint got, input longint exp_val);
		if (got != exp_val)
			flag_error($sformatf("%s is %0d, should be %0d", name, got, exp_val));
	endtask

	// Linear angle-to-pulse map, truncated toward zero, then clamped low before high.
	function automatic longint angle_to_duty(input longint ang);
		longint lo, hi, pl, ph, den, num, d;
		lo = longint'($signed(cfg.angle_low));
		hi = longint'($signed(cfg.angle_high));
		pl = longint'(cfg.pulse_low);
		ph = longint'(cfg.pulse_high);
		den = (hi - lo) * 256;
		if (den == 0) begin
			d = pl;
		end else begin
			num = (ang - lo * 256) * (ph - pl) + pl * den;
			d = num / den;
		end
		if (d < pl) d = pl;
		if (d > ph) d = ph;
		return d;
	endfunction

	function automatic void load_duty(input longint d);
		longint p, c;
		if (d < 0) d = 0;
		if (d > DUTY_TOP) d = DUTY_TOP;
		m_duty = d[13:0];
		if (m_paused) return;
		p = (cfg.period_len == 0) ? 1 : longint'(cfg.period_len);
		c = (longint'(m_duty) * p) >>> DEF_DUTY_BITS;
		if (c >= p) c = p - 1;
		m_pend = c[15:0];
	endfunction

	function automatic void advance_servo(input logic [2:0] op, input logic signed [17:0] val);
		pwm_result_t r;
		int p;
		p = (cfg.period_len == 0) ? 1 : int'(cfg.period_len);
		case (op)
			OP_ANGLE: load_duty(angle_to_duty(longint'(val)));
			OP_DUTY: load_duty(longint'(val));
			OP_PAUSE: begin
				if (!m_paused) begin
					m_pend = '0;
					m_paused = 1'b1;
				end
			end
			OP_RESUME: begin
				if (m_paused) begin
					m_paused = 1'b0;
					load_duty(longint'(m_duty));
				end
			end
			OP_TICK: begin
				// A counter left above a lowered period wraps on the next tick.
				if (int'(m_count) >= p - 1 || m_count == 16'hFFFF) begin
					m_count = '0;
					m_active = m_pend;
				end else begin
					m_count = m_count + 16'd1;
				end
			end
			default: ;
		endcase
		r.level = (m_count < m_active);
		r.cmp = m_active;
		r.duty = m_duty;
		r.paused = m_paused;
		pwm_result_q.push_back(r);
	endfunction

	function automatic void push_cmd(input logic [2:0] op, input logic signed [17:0] val);
		servo_cmd_t c;
		c.op = op;
		c.val = val;
		cmd_q.push_back(c);
	endfunction

	function automatic int rnd_angle();
		return int'($urandom_range(0, 720)) - 360;
	endfunction

	function automatic int rnd_pulse();
		return int'($urandom_range(0, 16383));
	endfunction

	function automatic servo_cmd_t random_cmd();
		servo_cmd_t c;
		int lo, hi, a, b, pick, tick_share;
		a = $signed(cfg.angle_low);
		b = $signed(cfg.angle_high);
		lo = ((a < b) ? a : b) * 256;
		hi = ((a < b) ? b : a) * 256;
		tick_share = (cfg.period_len < 1000) ? 45 : 8;
		pick = $urandom_range(0, 99);
		c.val = 18'($urandom);
		if (pick < tick_share) begin
			c.op = OP_TICK;
		end else if (pick < tick_share + 13) begin
			c.op = OP_DUTY;
			if ($urandom_range(0, 4) != 0) c.val = 18'($urandom_range(0, 16383));
		end else if (pick < tick_share + 19) begin
			c.op = OP_PAUSE;
		end else if (pick < tick_share + 25) begin
			c.op = OP_RESUME;
		end else if (pick < tick_share + 28) begin
			c.op = OP_TICK + 3'($urandom_range(1, 3));
		end else begin
			c.op = OP_ANGLE;
			// Mostly angles around the configured range, some anywhere.
			if ($urandom_range(0, 6) != 0)
				c.val = 18'(lo - 2560 + int'($urandom_range(0, hi - lo + 5120)));
		end
		return c;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ANGLE_LOW: cfg.angle_low = data[9:0];
			REG_ANGLE_HIGH: cfg.angle_high = data[9:0];
			REG_PULSE_LOW: cfg.pulse_low = data[13:0];
			REG_PULSE_HIGH: cfg.pulse_high = data[13:0];
			REG_PERIOD: cfg.period_len = data[15:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int al, input int ah, input int pl, input int ph, input int per);
		write_reg(REG_ANGLE_LOW, 32'(al));
		write_reg(REG_ANGLE_HIGH, 32'(ah));
		write_reg(REG_PULSE_LOW, 32'(pl));
		write_reg(REG_PULSE_HIGH, 32'(ph));
		write_reg(REG_PERIOD, 32'(per));
		@(negedge clk);
	endtask

	// Every transaction yields a result, so the block is idle once the last one is out.
	task automatic wait_idle();
		@(negedge clk);
		while (cmd_q.size() != 0 || in_valid || pwm_result_q.size() != 0)
			@(negedge clk);
	endtask

	// Sender: bursts of transactions separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= OP_TICK;
			value <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				advance_servo(opcode, value);
				n_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0 || cmd_q.size() == 0) begin
					if (gap_left > 0) gap_left--;
					in_valid <= 1'b0;
				end else begin
					next_cmd = cmd_q.pop_front();
					opcode <= next_cmd.op;
					value <= next_cmd.val;
					in_valid <= 1'b1;
					if (burst_left == 0) burst_left = $urandom_range(1, 50);
					burst_left--;
					if (burst_left == 0) begin
						case ($urandom_range(0, 9))
							0, 1, 2, 3, 4, 5: gap_left = $urandom_range(1, 3);
							6, 7, 8: gap_left = $urandom_range(4, 12);
							default: gap_left = $urandom_range(20, 60);
						endcase
					end
				end
			end
		end
	end

	// Receiver: checks each result and stalls in changing patterns.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pwm_result_q.size() == 0) begin
					flag_error("result with no transaction waiting for it");
				end else begin
					want = pwm_result_q.pop_front();
					compare_field("pwm_level", pwm_level, want.level);
					compare_field("compare_ticks", compare_ticks, want.cmp);
					compare_field("stored_duty", stored_duty, want.duty);
					compare_field("is_paused", is_paused, want.paused);
				end
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			stall_phase++;
			case (stall_mode)
				0: stall_next = 1'b0;
				1: stall_next = ($urandom_range(0, 99) < 30);
				2: stall_next = ((stall_phase % 7) < 3);
				default: stall_next = ($urandom_range(0, 99) < 75);
			endcase
			out_stall <= long_hold || stall_next;
		end
	end

	// Long receiver hold-off so the block backs up while the sender keeps offering.
	initial begin
		while (hold_at == 0 || n_taken < hold_at)
			@(posedge clk);
		long_hold <= 1'b1;
		repeat (500) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		cfg.angle_low = RST_ANGLE_LOW;
		cfg.angle_high = RST_ANGLE_HIGH;
		cfg.pulse_low = RST_PULSE_LOW;
		cfg.pulse_high = RST_PULSE_HIGH;
		cfg.period_len = RST_PERIOD;
		m_duty = '0;
		m_paused = 1'b0;
		m_pend = '0;
		m_active = '0;
		m_count = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: field extremes, pause and resume twice, writes while paused, unknown opcodes.
		push_cmd(OP_ANGLE, 18'sd0);
		push_cmd(OP_ANGLE, 18'sd46080);
		push_cmd(OP_ANGLE, -18'sd131072);
		push_cmd(OP_ANGLE, 18'sd131071);
		push_cmd(OP_ANGLE, 18'sd23040);
		push_cmd(OP_DUTY, -18'sd131072);
		push_cmd(OP_DUTY, 18'sd131071);
		push_cmd(OP_DUTY, 18'sd16384);
		push_cmd(OP_PAUSE, 18'sd0);
		push_cmd(OP_PAUSE, 18'sd0);
		push_cmd(OP_ANGLE, 18'sd11520);
		push_cmd(OP_DUTY, 18'sd700);
		push_cmd(OP_RESUME, 18'sd0);
		push_cmd(OP_RESUME, 18'sd0);
		push_cmd(OP_TICK + 3'd1, 18'sd5);
		push_cmd(OP_TICK + 3'd2, -18'sd1);
		push_cmd(OP_TICK + 3'd3, 18'sd77);
		push_cmd(OP_TICK, 18'sd0);
		wait_idle();

		// Equal angle range and swapped pulse range on a short period.
		set_config(45, 45, 16383, 0, 3);
		push_cmd(OP_ANGLE, 18'sd1000);
		push_cmd(OP_DUTY, 18'sd12000);
		push_cmd(OP_TICK, 18'sd0);
		push_cmd(OP_TICK, 18'sd0);
		push_cmd(OP_TICK, 18'sd0);
		push_cmd(OP_PAUSE, 18'sd0);
		push_cmd(OP_TICK, 18'sd0);
		push_cmd(OP_TICK, 18'sd0);
		wait_idle();

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: set_config(-360, 360, 0, 16383, 65535);
				1: set_config(0, 180, 400, 2090, 1);
				2: set_config(-90, 90, 1000, 2000, $urandom_range(3, 40));
				3: set_config(45, 45, 500, 600, 0);
				4: set_config(200, -100, 3000, 1500, $urandom_range(5, 60));
				5: set_config(360, -360, 16383, 0, 2);
				7: set_config(rnd_angle(), rnd_angle(), rnd_pulse(), rnd_pulse(), 65535);
				8: set_config(rnd_angle(), rnd_angle(), rnd_pulse(), rnd_pulse(),
						$urandom_range(3, 300));
				9: set_config(-360, 360, 0, 16383, $urandom_range(3, 20));
				default: set_config(rnd_angle(), rnd_angle(), rnd_pulse(), rnd_pulse(),
						$urandom_range(3, 64));
			endcase
			if (ph == 2) hold_at = n_taken + 20;
			repeat (115) cmd_q.push_back(random_cmd());
			wait_idle();
		end

		repeat (60) @(posedge clk);
		if (n_errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/sapg_pkg.sv
sv/sapg_cfg.sv
sv/sapg_mul.sv
sv/sapg_div.sv
sv/servo_angle_pwm_generator.sv
dv/tb_servo_angle_pwm_generator.sv
